[hdl/kpi_pkg.sv]
package kpi_pkg;

    localparam int MaxKeys   = 64;
    localparam int AddrW     = 6;
    localparam int CountW    = 7;
    localparam int FracBits  = 16;
    localparam int DataW     = 32;
    localparam int InDataW   = 200;
    localparam int OutDataW  = 328;

    localparam logic [1:0] TrkPos = 2'd0;
    localparam logic [1:0] TrkRot = 2'd1;
    localparam logic [1:0] TrkScl = 2'd2;

    localparam logic [1:0] CfgPosCount = 2'd0;
    localparam logic [1:0] CfgRotCount = 2'd1;
    localparam logic [1:0] CfgSclCount = 2'd2;

    localparam logic KindWrite = 1'b0;
    localparam logic KindQuery = 1'b1;

    localparam logic [DataW-1:0] FixOne = DataW'(1) << FracBits;

    // Lookup result classes.
    typedef enum logic [1:0] {
        LOC_EMPTY  = 2'd0,
        LOC_SINGLE = 2'd1,
        LOC_SEG    = 2'd2,
        LOC_ERR    = 2'd3
    } loc_t;

    // Shift-subtract divider start/done control.
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;

endpackage

[hdl/kpi_divider.sv]
// Unsigned restoring divider, one quotient bit per cycle.
module kpi_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic [63:0] quotient,
    output logic        busy,
    output logic        done
);
    import kpi_pkg::*;

    logic [63:0] quot_reg;
    logic [64:0] rem_reg;
    logic [63:0] dvs_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [64:0] trial;
    logic [64:0] diff;

    assign trial = {rem_reg[63:0], quot_reg[63]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
                quot_reg <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                if (!diff[64]) begin
                    rem_reg  <= diff;
                    quot_reg <= {quot_reg[62:0], 1'b1};
                end else begin
                    rem_reg  <= trial;
                    quot_reg <= {quot_reg[62:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient = quot_reg;
    assign busy     = busy_reg;
    assign done     = done_reg;

    assert property (@(posedge aclk) disable iff (!aresetn) done |-> !busy)
        else $error("divider done while busy");
    assert property (@(posedge aclk) disable iff (!aresetn) start |=> busy)
        else $error("divider did not start");
    assert property (@(posedge aclk) disable iff (!aresetn) $fell(busy) |-> done)
        else $error("divider stopped without done");

endmodule

[hdl/keyframe_pose_interpolator.sv]
// Keyframe pose interpolator.
// Input stream s_*: kind in s_tuser, other fields in s_tdata. A write item
// (kind 0) stores one key into a track slot and yields no result. A query
// item (kind 1) yields one result item on m_*: position, rotation (normalized
// when interpolated), scale and three error flags.
// Config port: cfg_wr_en / cfg_index / cfg_data set the per-track key counts;
// write only while idle.
// A write is taken while idle; the next item can follow at once.
// A query scans each track's keys through ST_SCAN and ST_RD, runs the serial
// divider for the norm of each track that lands in a segment, passes each
// lerp component through ST_LRD, ST_LMUL, ST_LPRD and ST_LADD, then for an
// interpolated rotation does four squares, a bit-serial square root and four
// more divisions; the key scan and the one-bit-a-cycle divider dominate.
// One item at a time: s_tready is low from acceptance until the result is
// taken. When the receiver stalls, the result holds in the output register.
// Reset (aresetn low, synchronous) clears counts and control; key memories
// are not cleared and read undefined until written.
module keyframe_pose_interpolator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // track[1:0], key_index[7:2], key_time[39:8], comp_x, comp_y, comp_z,
    // comp_w, query_time[199:168], packed from bit 0
    input  logic [kpi_pkg::InDataW-1:0]   s_tdata,
    input  logic                          s_tuser,   // kind
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // pos_x,pos_y,pos_z,rot_w,rot_x,rot_y,rot_z,scl_x,scl_y,scl_z,error_flags
    output logic [kpi_pkg::OutDataW-1:0]  m_tdata,
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_index,
    input  logic [kpi_pkg::CountW-1:0]    cfg_data
);
    import kpi_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN, ST_RD, ST_DIVST, ST_DIVW, ST_LRD, ST_LMUL, ST_LPRD, ST_LADD,
        ST_NEXT, ST_SQ, ST_SQRT, ST_QDIV, ST_QDIVW, ST_OUT
    } state_t;

    // key memories: one array per component (time, x, y, z), indexed by track
    // and key; rot w uses a separate array
    logic [DataW-1:0] mem_time [3][MaxKeys];
    logic [DataW-1:0] mem_x [3][MaxKeys];
    logic [DataW-1:0] mem_y [3][MaxKeys];
    logic [DataW-1:0] mem_z [3][MaxKeys];
    logic [DataW-1:0] mem_w [MaxKeys];

    state_t           state_reg;
    logic [CountW-1:0] cnt_reg [3];
    logic [1:0]       trk_reg;
    logic [AddrW:0]   idx_reg;
    logic [DataW-1:0] qt_reg;
    logic [DataW-1:0] rd_t_reg;
    logic [DataW-1:0] t0_reg;
    logic [2:0]       flags_reg;
    loc_t             loc_reg;
    logic [2:0]       comp_reg;
    logic [63:0]      norm_reg;
    logic signed [DataW-1:0] va_reg, vb_reg;
    logic signed [63:0] prod_reg;
    logic signed [DataW-1:0] res_reg [10];
    logic [63:0]      s_reg;
    logic [63:0]      sq_rem_reg;
    logic [31:0]      root_reg;
    logic [5:0]       sq_cnt_reg;
    logic             m_valid_reg;
    logic [63:0]      div_a, div_b, div_q;
    logic             div_start, div_busy, div_done;
    logic [AddrW-1:0] ra;
    logic [CountW-1:0] ncnt;
    logic [1:0]       wtrk;
    logic [AddrW-1:0] widx;

    kpi_divider u_div (
        .aclk, .aresetn, .start(div_start), .dividend(div_a), .divisor(div_b),
        .quotient(div_q), .busy(div_busy), .done(div_done)
    );

    assign wtrk = s_tdata[1:0];
    assign widx = s_tdata[7:2];

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready && s_tuser == KindWrite && wtrk != 2'd3) begin
            mem_time[wtrk][widx] <= s_tdata[39:8];
            mem_x[wtrk][widx]    <= s_tdata[71:40];
            mem_y[wtrk][widx]    <= s_tdata[103:72];
            mem_z[wtrk][widx]    <= s_tdata[135:104];
            if (wtrk == TrkRot) begin
                mem_w[widx] <= s_tdata[167:136];
            end
        end
    end

    assign ra = idx_reg[AddrW-1:0];
    assign ncnt = (cnt_reg[trk_reg] > CountW'(MaxKeys)) ? CountW'(MaxKeys) : cnt_reg[trk_reg];

    logic [DataW-1:0] mem_rd_val;
    always_comb begin
        case (comp_reg)
            3'd0: mem_rd_val = (trk_reg == TrkRot) ? mem_w[ra] : mem_x[trk_reg][ra];
            3'd1: mem_rd_val = (trk_reg == TrkRot) ? mem_x[trk_reg][ra] : mem_y[trk_reg][ra];
            3'd2: mem_rd_val = (trk_reg == TrkRot) ? mem_y[trk_reg][ra] : mem_z[trk_reg][ra];
            default: mem_rd_val = mem_z[trk_reg][ra];
        endcase
    end

    logic [3:0] base;
    logic [2:0] ncomp;
    assign base  = (trk_reg == TrkPos) ? 4'd0 : (trk_reg == TrkRot) ? 4'd3 : 4'd7;
    assign ncomp = (trk_reg == TrkRot) ? 3'd4 : 3'd3;

    logic [3:0] slot;
    assign slot = base + 4'(comp_reg);

    logic signed [DataW-1:0] dflt;
    always_comb begin
        dflt = '0;
        if (trk_reg == TrkScl || (trk_reg == TrkRot && comp_reg == 3'd0)) dflt = FixOne;
    end

    logic [65:0] sq_trial;
    assign sq_trial = {sq_rem_reg[61:0], s_reg[63:62]} - {32'd0, root_reg, 2'b01};

    logic signed [DataW-1:0] rcomp;
    logic [DataW-1:0] rmag;
    assign rcomp = res_reg[4'd3 + 4'(comp_reg)];
    assign rmag  = rcomp[DataW-1] ? DataW'(-rcomp) : rcomp;

    // length sum of squares, saturating at all ones
    logic [63:0] sq_term;
    logic [64:0] sq_sum;
    assign sq_term = 64'(rmag) * 64'(rmag);
    assign sq_sum  = {1'b0, s_reg} + {1'b0, sq_term};

    logic signed [63:0] fl;
    assign fl = prod_reg >>> FracBits;

    always_comb begin
        div_start = 1'b0;
        div_a = '0;
        div_b = '0;
        if (state_reg == ST_DIVST) begin
            div_start = 1'b1;
            div_a = {16'd0, qt_reg - t0_reg, 16'd0};
            div_b = {32'd0, rd_t_reg - t0_reg};
        end else if (state_reg == ST_QDIV && root_reg != '0) begin
            div_start = 1'b1;
            div_a = {16'd0, rmag, 16'd0};
            div_b = {32'd0, root_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg[0]  <= '0;
            cnt_reg[1]  <= '0;
            cnt_reg[2]  <= '0;
            trk_reg     <= TrkPos;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CfgPosCount: cnt_reg[0] <= cfg_data;
                    CfgRotCount: cnt_reg[1] <= cfg_data;
                    CfgSclCount: cnt_reg[2] <= cfg_data;
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && s_tuser == KindQuery) begin
                        qt_reg    <= s_tdata[199:168];
                        trk_reg   <= TrkPos;
                        flags_reg <= '0;
                        idx_reg   <= '0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    comp_reg <= '0;
                    if (ncnt == '0) begin
                        loc_reg <= LOC_EMPTY;
                        state_reg <= ST_LADD;
                    end else if (ncnt == CountW'(1)) begin
                        loc_reg <= LOC_SINGLE;
                        idx_reg <= '0;
                        state_reg <= ST_LADD;
                    end else if (CountW'(idx_reg) + CountW'(1) >= ncnt) begin
                        loc_reg <= LOC_ERR;
                        flags_reg[trk_reg] <= 1'b1;
                        state_reg <= ST_LADD;
                    end else begin
                        t0_reg   <= mem_time[trk_reg][ra];
                        rd_t_reg <= mem_time[trk_reg][AddrW'(idx_reg + 1'b1)];
                        state_reg <= ST_RD;
                    end
                end
                ST_RD: begin
                    if (qt_reg < rd_t_reg) begin
                        if (rd_t_reg <= t0_reg || qt_reg < t0_reg) begin
                            loc_reg <= LOC_ERR;
                            flags_reg[trk_reg] <= 1'b1;
                            state_reg <= ST_LADD;
                        end else begin
                            loc_reg <= LOC_SEG;
                            state_reg <= ST_DIVST;
                        end
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_DIVST: state_reg <= ST_DIVW;
                ST_DIVW: if (div_done) begin
                    norm_reg  <= div_q;
                    state_reg <= ST_LRD;
                end
                ST_LRD: begin
                    va_reg <= mem_rd_val;
                    idx_reg <= idx_reg + 1'b1;
                    state_reg <= ST_LMUL;
                end
                ST_LMUL: begin
                    vb_reg <= mem_rd_val;
                    idx_reg <= idx_reg - 1'b1;
                    state_reg <= ST_LPRD;
                end
                ST_LPRD: begin
                    prod_reg <= (64'(vb_reg) - 64'(va_reg))
                                * signed'({1'b0, norm_reg[16:0]});
                    state_reg <= ST_LADD;
                end
                ST_LADD: begin
                    case (loc_reg)
                        LOC_SEG:    res_reg[slot] <= va_reg + DataW'(fl);
                        LOC_SINGLE: res_reg[slot] <= mem_rd_val;
                        default:    res_reg[slot] <= dflt;
                    endcase
                    if (comp_reg + 3'd1 < ncomp) begin
                        comp_reg  <= comp_reg + 3'd1;
                        state_reg <= (loc_reg == LOC_SEG) ? ST_LRD : ST_LADD;
                    end else begin
                        state_reg <= ST_NEXT;
                    end
                end
                ST_NEXT: begin
                    comp_reg <= '0;
                    idx_reg  <= '0;
                    s_reg    <= '0;
                    if (trk_reg == TrkRot && loc_reg == LOC_SEG) begin
                        state_reg <= ST_SQ;
                    end else if (trk_reg == TrkScl) begin
                        state_reg <= ST_OUT;
                        m_valid_reg <= 1'b1;
                    end else begin
                        trk_reg   <= trk_reg + 2'd1;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SQ: begin
                    // 32x32 square per cycle, sum of four
                    s_reg <= sq_sum[64] ? '1 : sq_sum[63:0];
                    if (comp_reg == 3'd3) begin
                        comp_reg   <= '0;
                        sq_rem_reg <= '0;
                        root_reg   <= '0;
                        sq_cnt_reg <= 6'd32;
                        state_reg  <= ST_SQRT;
                    end else begin
                        comp_reg <= comp_reg + 3'd1;
                    end
                end
                ST_SQRT: begin
                    s_reg <= {s_reg[61:0], 2'b00};
                    if (!sq_trial[65]) begin
                        sq_rem_reg <= sq_trial[63:0];
                        root_reg   <= {root_reg[30:0], 1'b1};
                    end else begin
                        sq_rem_reg <= {sq_rem_reg[61:0], s_reg[63:62]};
                        root_reg   <= {root_reg[30:0], 1'b0};
                    end
                    sq_cnt_reg <= sq_cnt_reg - 6'd1;
                    if (sq_cnt_reg == 6'd1) state_reg <= ST_QDIV;
                end
                ST_QDIV: begin
                    if (root_reg == '0) begin
                        res_reg[3] <= FixOne;
                        res_reg[4] <= '0;
                        res_reg[5] <= '0;
                        res_reg[6] <= '0;
                        trk_reg   <= TrkScl;
                        state_reg <= ST_SCAN;
                    end else begin
                        state_reg <= ST_QDIVW;
                    end
                end
                ST_QDIVW: if (div_done) begin
                    res_reg[4'd3 + 4'(comp_reg)] <= rcomp[DataW-1] ? DataW'(-div_q) : DataW'(div_q);
                    if (comp_reg == 3'd3) begin
                        comp_reg  <= '0;
                        trk_reg   <= TrkScl;
                        state_reg <= ST_SCAN;
                    end else begin
                        comp_reg  <= comp_reg + 3'd1;
                        state_reg <= ST_QDIV;
                    end
                end
                ST_OUT: if (m_tready) begin
                    m_valid_reg <= 1'b0;
                    state_reg   <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, flags_reg, res_reg[9], res_reg[8], res_reg[7], res_reg[6],
                       res_reg[5], res_reg[4], res_reg[3], res_reg[2], res_reg[1],
                       res_reg[0]};

    assert property (@(posedge aclk) disable iff (!aresetn) m_tvalid |-> !s_tready)
        else $error("input open while result pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("result changed under stall");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVST) |=> div_busy)
        else $error("divider not started");

endmodule
